>>> hdl/lcg_and_lagged_xor_random_generator_macros.svh
// assertion macros shared by the generator modules
// depends on nothing; included by files that carry assertions
`ifndef LCG_AND_LAGGED_XOR_RANDOM_GENERATOR_MACROS_SVH
`define LCG_AND_LAGGED_XOR_RANDOM_GENERATOR_MACROS_SVH

// property must hold on every clock outside reset
`define LXR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked from the next cycle on
`define LXR_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

>>> hdl/lxr_pkg.sv
// shared types and constants of the lcg and lagged xor generator
// depends on nothing
package lxr_pkg;

  localparam int unsigned RingDepthDefault = 64;
  localparam logic [63:0] LcgMul = 64'd6364136223846793005;
  // lcg multiplier split into 32-bit halves for the partial products
  localparam logic [31:0] LcgMulLo = 32'h4C95_7F2D;
  localparam logic [31:0] LcgMulHi = 32'h5851_F42D;
  localparam int unsigned LagShort = 24;
  localparam int unsigned LagLong = 55;
  localparam int unsigned SeedLast = 54;

  typedef enum logic [2:0] {
    OP_SEED_LCG   = 3'd0,
    OP_LCG_DRAW   = 3'd1,
    OP_SEED_WORDS = 3'd2,
    OP_SEED_RING  = 3'd3,
    OP_RING_DRAW  = 3'd4,
    OP_JOINT_DRAW = 3'd5
  } op_t;

  // one queued command from front to back
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] seed_low;
    logic [31:0] seed_high;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LCG_MUL,
    ST_LCG_ADD,
    ST_RING_RD,
    ST_RING_WR,
    ST_JOINT,
    ST_WSEED_RD,
    ST_WSEED_MUL,
    ST_WSEED_WR,
    ST_LSEED_MUL,
    ST_LSEED_ADD,
    ST_OUT
  } st_t;

endpackage

>>> hdl/lxr_front.sv
// front part: takes input transfers, drops unused codes, two-entry command queue
// depends on lxr_pkg
module lxr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_operation,
  input  logic [31:0]      in_seed_low,
  input  logic [31:0]      in_seed_high,
  output logic             cmd_valid,
  output lxr_pkg::cmd_t    cmd,
  input  logic             cmd_take
);

  lxr_pkg::cmd_t q_r [2];
  logic          rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, useful;

  // codes 6 and 7 are accepted and dropped
  assign useful    = (in_operation <= 3'(lxr_pkg::OP_JOINT_DRAW));
  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall && useful;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ cmd_take;
    wr_ptr_nxt = wr_ptr_r ^ push;
    cnt_nxt    = cnt_r + 2'(push) - 2'(cmd_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: in_operation, seed_low: in_seed_low, seed_high: in_seed_high};
    end
  end

`include "lcg_and_lagged_xor_random_generator_macros.svh"
  `LXR_ASSERT(a_cnt_range, cnt_r <= 2'd2, "queue count out of range")
  `LXR_ASSERT(a_no_take_empty, !(cmd_take && cnt_r == 2'd0), "take from empty queue")
  `LXR_ASSERT_NEXT(a_full_stall, cnt_r == 2'd2 && !cmd_take, in_stall, "full queue lost stall")

endmodule

>>> hdl/lxr_back.sv
// back part: lcg, ring memory and sequencer for draws and seeding
// depends on lxr_pkg
module lxr_back #(
  parameter int unsigned RING_DEPTH = lxr_pkg::RingDepthDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  lxr_pkg::cmd_t  cmd,
  output logic           cmd_take,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    out_random_value
);

  localparam int unsigned IW = $clog2(RING_DEPTH);

  lxr_pkg::st_t  st_r, st_nxt;
  lxr_pkg::cmd_t cur_r;
  logic [31:0]   ram [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld_r;
  logic [63:0]   lcg_r, plo_r, lcg_step;
  logic [31:0]   pca_r, pcb_r;
  logic [IW-1:0] idx_r, k_r;
  logic          half_r;
  logic [15:0]   lo_r, lcg_out_r;
  logic [31:0]   rd_a_r, rd_b_r, ea, eb, w_xor, res_r;
  logic [31:0]   m11_r, m19_r, prev1_r, prev2_r;
  logic          rd_phase_r;
  logic          start;
  logic [IW-1:0] nidx;

  assign nidx     = idx_r + IW'(1);
  assign start    = (st_r == lxr_pkg::ST_IDLE) && cmd_valid;
  assign cmd_take = start;
  assign out_valid = (st_r == lxr_pkg::ST_OUT);
  assign out_random_value = res_r;
  assign ea = rd_a_r;
  assign eb = rd_b_r;

  // next lcg state from the registered partial products, modulo 2^64
  assign lcg_step = plo_r + {pca_r + pcb_r, 32'd0} + 64'd1;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      lxr_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (lxr_pkg::op_t'(cmd.op))
            lxr_pkg::OP_SEED_LCG:   st_nxt = lxr_pkg::ST_IDLE;
            lxr_pkg::OP_LCG_DRAW:   st_nxt = lxr_pkg::ST_LCG_MUL;
            lxr_pkg::OP_JOINT_DRAW: st_nxt = lxr_pkg::ST_LCG_MUL;
            lxr_pkg::OP_SEED_RING:  st_nxt = lxr_pkg::ST_LSEED_MUL;
            lxr_pkg::OP_SEED_WORDS: st_nxt = lxr_pkg::ST_WSEED_RD;
            lxr_pkg::OP_RING_DRAW:  st_nxt = lxr_pkg::ST_RING_RD;
            default:                st_nxt = lxr_pkg::ST_IDLE;
          endcase
        end
      end
      lxr_pkg::ST_LCG_MUL: st_nxt = lxr_pkg::ST_LCG_ADD;
      lxr_pkg::ST_LCG_ADD: st_nxt = (cur_r.op == 3'(lxr_pkg::OP_JOINT_DRAW)) ?
                                    lxr_pkg::ST_RING_RD : lxr_pkg::ST_OUT;
      lxr_pkg::ST_RING_RD: st_nxt = lxr_pkg::ST_RING_WR;
      lxr_pkg::ST_RING_WR: st_nxt = (cur_r.op == 3'(lxr_pkg::OP_JOINT_DRAW)) ?
                                    lxr_pkg::ST_JOINT : lxr_pkg::ST_OUT;
      lxr_pkg::ST_JOINT:   st_nxt = lxr_pkg::ST_OUT;
      lxr_pkg::ST_WSEED_RD:  st_nxt = lxr_pkg::ST_WSEED_MUL;
      lxr_pkg::ST_WSEED_MUL: st_nxt = lxr_pkg::ST_WSEED_WR;
      lxr_pkg::ST_WSEED_WR:  st_nxt = (k_r == IW'(lxr_pkg::SeedLast)) ?
                                      lxr_pkg::ST_IDLE : lxr_pkg::ST_WSEED_MUL;
      lxr_pkg::ST_LSEED_MUL: st_nxt = lxr_pkg::ST_LSEED_ADD;
      lxr_pkg::ST_LSEED_ADD: st_nxt = (half_r && k_r == IW'(RING_DEPTH - 1)) ?
                                      lxr_pkg::ST_IDLE : lxr_pkg::ST_LSEED_MUL;
      lxr_pkg::ST_OUT:     st_nxt = out_stall ? lxr_pkg::ST_OUT : lxr_pkg::ST_IDLE;
      default:             st_nxt = lxr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= lxr_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  // lcg state, ring index and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_r  <= '0;
      idx_r  <= '0;
      vld_r  <= '0;
    end else begin
      if (start && cmd.op == 3'(lxr_pkg::OP_SEED_LCG)) lcg_r <= {cmd.seed_high, cmd.seed_low};
      if (st_r == lxr_pkg::ST_LCG_ADD || st_r == lxr_pkg::ST_LSEED_ADD) begin
        lcg_r <= lcg_step;
      end
      if (st_r == lxr_pkg::ST_RING_WR) begin
        idx_r <= nidx;
        vld_r[nidx] <= 1'b1;
      end
      if (start && cmd.op == 3'(lxr_pkg::OP_SEED_WORDS)) begin
        vld_r[0] <= 1'b1;
        vld_r[1] <= 1'b1;
      end
      if (st_r == lxr_pkg::ST_WSEED_WR) vld_r[k_r] <= 1'b1;
      if (st_r == lxr_pkg::ST_LSEED_ADD && half_r) vld_r[k_r] <= 1'b1;
    end
  end

  // datapath registers; seed words start at entry 2 with the two given words
  always_ff @(posedge clk) begin
    if (start) begin
      cur_r  <= cmd;
      k_r    <= (cmd.op == 3'(lxr_pkg::OP_SEED_WORDS)) ? IW'(2) : '0;
      half_r <= 1'b0;
      prev2_r <= cmd.seed_low;
      prev1_r <= cmd.seed_high;
    end
    // three 32x32 partial products of the 64-bit lcg multiply
    if (st_r == lxr_pkg::ST_LCG_MUL || st_r == lxr_pkg::ST_LSEED_MUL) begin
      plo_r <= 64'(lcg_r[31:0]) * 64'(lxr_pkg::LcgMulLo);
      pca_r <= lcg_r[31:0] * lxr_pkg::LcgMulHi;
      pcb_r <= lcg_r[63:32] * lxr_pkg::LcgMulLo;
    end
    if (st_r == lxr_pkg::ST_LCG_ADD) lcg_out_r <= lcg_step[63:48];
    if (st_r == lxr_pkg::ST_LCG_ADD && cur_r.op == 3'(lxr_pkg::OP_LCG_DRAW)) begin
      res_r <= {16'd0, lcg_step[63:48]};
    end
    if (st_r == lxr_pkg::ST_RING_WR) begin
      if (cur_r.op == 3'(lxr_pkg::OP_RING_DRAW)) res_r <= w_xor;
      else res_r <= w_xor;
    end
    if (st_r == lxr_pkg::ST_JOINT) res_r <= {16'd0, lcg_out_r} * res_r;
    if (st_r == lxr_pkg::ST_WSEED_MUL) begin
      m11_r <= prev1_r * 32'd11;
      m19_r <= prev2_r * 32'd19;
    end
    if (st_r == lxr_pkg::ST_WSEED_WR) begin
      prev2_r <= prev1_r;
      prev1_r <= m11_r + (m19_r >> 4);
      k_r     <= k_r + IW'(1);
    end
    if (st_r == lxr_pkg::ST_LSEED_ADD) begin
      half_r <= !half_r;
      if (!half_r) lo_r <= lcg_step[63:48];
      else k_r <= k_r + IW'(1);
    end
  end

  // xor of the two lagged entries; unwritten entries read as zero
  always_comb begin
    w_xor = (rd_phase_r ? ea : 32'd0) ^ (rd_phase_r ? eb : 32'd0);
  end

  // ring memory: two read ports, one write port, registered reads
  always_ff @(posedge clk) begin
    if (st_r == lxr_pkg::ST_RING_RD) begin
      rd_a_r <= vld_r[nidx - IW'(lxr_pkg::LagShort)] ? ram[nidx - IW'(lxr_pkg::LagShort)] : 32'd0;
      rd_b_r <= vld_r[nidx - IW'(lxr_pkg::LagLong)] ? ram[nidx - IW'(lxr_pkg::LagLong)] : 32'd0;
    end
    if (st_r == lxr_pkg::ST_RING_WR) ram[nidx] <= w_xor;
    if (st_r == lxr_pkg::ST_WSEED_RD) begin
      ram[0] <= cur_r.seed_low;
    end
    if (st_r == lxr_pkg::ST_WSEED_MUL && k_r == IW'(2)) ram[1] <= cur_r.seed_high;
    if (st_r == lxr_pkg::ST_WSEED_WR) ram[k_r] <= m11_r + (m19_r >> 4);
    if (st_r == lxr_pkg::ST_LSEED_ADD && half_r) ram[k_r] <= {lcg_step[63:48], lo_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_phase_r <= 1'b0;
    else        rd_phase_r <= (st_r == lxr_pkg::ST_RING_RD);
  end

`include "lcg_and_lagged_xor_random_generator_macros.svh"
  `LXR_ASSERT(a_out_state, out_valid == (st_r == lxr_pkg::ST_OUT), "result shown outside output state")
  `LXR_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(res_r), "stalled result changed")
  `LXR_ASSERT_NEXT(a_xor_phase, st_r == lxr_pkg::ST_RING_RD, rd_phase_r, "ring write without read")

endmodule

>>> hdl/lcg_and_lagged_xor_random_generator.sv
// Random generator: a 64-bit lcg draws bits 63..48, a 64-entry lagged xor ring
// (lags 24 and 55) draws 32 bits, a joint draw multiplies both modulo 2^32.
// One item is worked at a time by the back sequencer; a two-entry queue in front
// keeps accepting until full. An lcg draw runs a start step, a step of three
// 32x32 partial products and an add; a ring draw a start, a read and a write;
// a joint draw both chains, then a multiply. Each result is held until taken.
// Seeding the lcg is done at start; the ring is seeded from words by a multiply
// and a write per word, or from the lcg by one 16-bit half per lcg step.
// No clearing pass after reset: per-entry valid bits make the ring read zero.
// depends on lxr_pkg, lxr_front, lxr_back
module lcg_and_lagged_xor_random_generator #(
  parameter int unsigned RING_DEPTH = lxr_pkg::RingDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_seed_low,
  input  logic [31:0] in_seed_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_random_value
);

  logic          cmd_valid, cmd_take;
  lxr_pkg::cmd_t cmd;

  // input side and command queue
  lxr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation, .in_seed_low, .in_seed_high,
    .cmd_valid, .cmd, .cmd_take
  );

  // generators and sequencer
  lxr_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .out_valid, .out_stall, .out_random_value
  );

endmodule
